// ===== src/rea_pkg.sv =====
package rea_pkg;

  localparam int unsigned AccW  = 67;
  localparam int unsigned OpAW  = 38;
  localparam int unsigned OpBW  = 22;
  localparam int unsigned DenW  = 60;
  localparam int unsigned RemW  = 61;
  localparam int unsigned QuoW  = 48;
  localparam int unsigned SumW  = 48;

  // Register indexes of the configuration port.
  localparam logic [3:0] RegRot0 = 4'd0;
  localparam logic [3:0] RegRot1 = 4'd1;
  localparam logic [3:0] RegRot2 = 4'd2;
  localparam logic [3:0] RegCxy  = 4'd3;
  localparam logic [3:0] RegCz   = 4'd4;
  localparam logic [3:0] RegKin0 = 4'd5;
  localparam logic [3:0] RegKin1 = 4'd6;
  localparam logic [3:0] RegKin2 = 4'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MAC,
    OP_MACSH,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQ_INIT,
    OP_SQ_STEP
  } rea_op_e;

  typedef struct packed {
    rea_op_e                  op;
    logic signed [OpAW-1:0]   a;
    logic signed [OpBW-1:0]   b;
    logic [DenW-1:0]          den;
    logic [RemW-1:0]          init;
    logic [1:0]               bits;
  } rea_ctl_t;

  typedef struct packed {
    logic signed [AccW-1:0]   acc;
    logic [QuoW-1:0]          quo;
    logic                     ovf;
  } rea_sts_t;

endpackage

// ===== src/reprojection_error_accumulator.sv =====
// One point is in work at a time, and a zero depth ends its work after the matrix products.
// The shared multiply/divide/square-root unit runs its steps one after another: the matrix
// products (18 multiplies), two divisions, the squares and a 32-step square root.
// A stalled result holds the block until it is taken.
// Asynchronous active-low reset clears the registers, the running sum and all control.
module reprojection_error_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] observed_u_i,
  input  logic signed [31:0] observed_v_i,
  input  logic               last_point_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        point_error_o,
  output logic [47:0]        error_sum_o,
  output logic               depth_fault_o,
  output logic               batch_end_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);
  import rea_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MAT, S_DIVI, S_DIVS, S_DIVE, S_DIFF, S_SQR, S_SQS, S_SQE, S_ACC
  } state_e;

  state_e state_q;

  logic [47:0]        rot_q [3];
  logic [62:0]        kin_q [3];
  logic [63:0]        cxy_q;
  logic [31:0]        cz_q;

  logic signed [32:0] d_q [3];
  logic signed [37:0] b_q [3];
  logic signed [59:0] q_q [3];
  logic signed [31:0] obs_u_q, obs_v_q;
  logic signed [48:0] proj_q [2];
  logic [31:0]        ax_q, ay_q;
  logic               last_q, fault_q, sat_q;
  logic [31:0]        err_q;
  logic [SumW-1:0]    accum_q;
  logic [63:0]        sh_q;
  logic [1:0]         row_q, col_q;
  logic               kphase_q, sel_q;
  logic [5:0]         cnt_q;

  logic               out_valid_q;
  logic [31:0]        point_error_q;
  logic [47:0]        error_sum_q;
  logic               depth_fault_q, batch_end_q;

  rea_ctl_t           ctl;
  rea_sts_t           sts;

  logic [59:0]        mag_num, mag_den;
  logic signed [AccW-1:0] rnd;
  logic signed [49:0] dx, dy;
  logic [49:0]        adx, ady;
  logic [SumW:0]      sum_w;
  logic [SumW-1:0]    sum_sat;
  logic               q_neg;

  rea_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .sts_o  (sts)
  );

  assign mag_den = q_q[2][59] ? 60'(-q_q[2]) : 60'(q_q[2]);
  assign mag_num = (sel_q ? q_q[1][59] : q_q[0][59]) ?
                   60'(-(sel_q ? q_q[1] : q_q[0])) : 60'(sel_q ? q_q[1] : q_q[0]);
  assign q_neg   = ((sel_q ? q_q[1][59] : q_q[0][59]) == q_q[2][59]);
  assign rnd     = (sts.acc + AccW'(8192)) >>> 14;
  assign dx      = 50'(obs_u_q) - 50'(proj_q[0]);
  assign dy      = 50'(obs_v_q) - 50'(proj_q[1]);
  assign adx     = dx[49] ? 50'(-dx) : 50'(dx);
  assign ady     = dy[49] ? 50'(-dy) : 50'(dy);
  assign sum_w   = {1'b0, accum_q} + (SumW+1)'(err_q);
  assign sum_sat = sum_w[SumW] ? '1 : sum_w[SumW-1:0];

  // Operand selection for the shared unit.
  always_comb begin
    ctl      = '0;
    ctl.op   = OP_NOP;
    ctl.den  = mag_den;
    ctl.init = RemW'(mag_num[59:32]);
    unique case (state_q)
      S_MAT: begin
        if (col_q != 2'd3) begin
          ctl.op = (col_q == 2'd0) ? OP_LOAD : OP_MAC;
          case (col_q)
            2'd0: begin
              ctl.a = kphase_q ? b_q[0] : 38'(d_q[0]);
              ctl.b = kphase_q ? 22'($signed(kin_q[row_q][20:0]))
                               : 22'($signed(rot_q[row_q][15:0]));
            end
            2'd1: begin
              ctl.a = kphase_q ? b_q[1] : 38'(d_q[1]);
              ctl.b = kphase_q ? 22'($signed(kin_q[row_q][41:21]))
                               : 22'($signed(rot_q[row_q][31:16]));
            end
            default: begin
              ctl.a = kphase_q ? b_q[2] : 38'(d_q[2]);
              ctl.b = kphase_q ? 22'($signed(kin_q[row_q][62:42]))
                               : 22'($signed(rot_q[row_q][47:32]));
            end
          endcase
        end
      end
      S_DIVI: ctl.op = OP_DIV_INIT;
      S_DIVS: begin
        ctl.op   = OP_DIV_STEP;
        ctl.bits = {1'b0, sh_q[63]};
      end
      S_SQR: begin
        // Squares are built from two 32x16 partial products each.
        case (cnt_q[2:0])
          3'd0: begin ctl.op = OP_LOAD;  ctl.a = 38'(ax_q); ctl.b = 22'(ax_q[15:0]);  end
          3'd1: begin ctl.op = OP_MACSH; ctl.a = 38'(ax_q); ctl.b = 22'(ax_q[31:16]); end
          3'd2: begin ctl.op = OP_MAC;   ctl.a = 38'(ay_q); ctl.b = 22'(ay_q[15:0]);  end
          3'd3: begin ctl.op = OP_MACSH; ctl.a = 38'(ay_q); ctl.b = 22'(ay_q[31:16]); end
          default: ctl.op = OP_SQ_INIT;
        endcase
      end
      S_SQS: begin
        ctl.op   = OP_SQ_STEP;
        ctl.bits = sh_q[63:62];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      rot_q         <= '{default: '0};
      kin_q         <= '{default: '0};
      cxy_q         <= '0;
      cz_q          <= '0;
      d_q           <= '{default: '0};
      b_q           <= '{default: '0};
      q_q           <= '{default: '0};
      proj_q        <= '{default: '0};
      obs_u_q       <= '0;
      obs_v_q       <= '0;
      ax_q          <= '0;
      ay_q          <= '0;
      last_q        <= 1'b0;
      fault_q       <= 1'b0;
      sat_q         <= 1'b0;
      err_q         <= '0;
      accum_q       <= '0;
      sh_q          <= '0;
      row_q         <= '0;
      col_q         <= '0;
      kphase_q      <= 1'b0;
      sel_q         <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      point_error_q <= '0;
      error_sum_q   <= '0;
      depth_fault_q <= 1'b0;
      batch_end_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegRot0: rot_q[0] <= cfg_data_i[47:0];
          RegRot1: rot_q[1] <= cfg_data_i[47:0];
          RegRot2: rot_q[2] <= cfg_data_i[47:0];
          RegCxy:  cxy_q    <= cfg_data_i;
          RegCz:   cz_q     <= cfg_data_i[31:0];
          RegKin0: kin_q[0] <= cfg_data_i[62:0];
          RegKin1: kin_q[1] <= cfg_data_i[62:0];
          RegKin2: kin_q[2] <= cfg_data_i[62:0];
          default: ;
        endcase
      end

      // In S_ACC the output register is handled by the state machine below.
      if (out_valid_q && !out_stall_i && state_q != S_ACC) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            d_q[0]   <= 33'(point_x_i) - 33'($signed(cxy_q[31:0]));
            d_q[1]   <= 33'(point_y_i) - 33'($signed(cxy_q[63:32]));
            d_q[2]   <= 33'(point_z_i) - 33'($signed(cz_q));
            obs_u_q  <= observed_u_i;
            obs_v_q  <= observed_v_i;
            last_q   <= last_point_i;
            fault_q  <= 1'b0;
            sat_q    <= 1'b0;
            row_q    <= '0;
            col_q    <= '0;
            kphase_q <= 1'b0;
            state_q  <= S_MAT;
          end
        end
        S_MAT: begin
          col_q <= col_q + 2'd1;
          if (col_q == 2'd3) begin
            if (kphase_q) begin
              q_q[row_q] <= sts.acc[59:0];
            end else begin
              b_q[row_q] <= rnd[37:0];
            end
            row_q <= row_q + 2'd1;
            if (row_q == 2'd2) begin
              row_q <= '0;
              if (!kphase_q) begin
                kphase_q <= 1'b1;
              end else if (sts.acc[59:0] == '0) begin
                fault_q <= 1'b1;
                err_q   <= '1;
                state_q <= S_ACC;
              end else begin
                sel_q   <= 1'b0;
                state_q <= S_DIVI;
              end
            end
          end
        end
        S_DIVI: begin
          // The numerator is the magnitude scaled by 2^16; its low 32 bits feed the steps.
          sh_q    <= {mag_num[31:0], 32'd0};
          cnt_q   <= '0;
          state_q <= S_DIVS;
        end
        S_DIVS: begin
          sh_q  <= {sh_q[62:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd47) begin
            state_q <= S_DIVE;
          end
        end
        S_DIVE: begin
          if (sts.ovf) begin
            sat_q <= 1'b1;
          end
          proj_q[sel_q] <= q_neg ? -$signed({1'b0, sts.quo}) : $signed({1'b0, sts.quo});
          if (!sel_q) begin
            sel_q   <= 1'b1;
            state_q <= S_DIVI;
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (sat_q || adx[49:32] != '0 || ady[49:32] != '0) begin
            err_q   <= '1;
            state_q <= S_ACC;
          end else begin
            ax_q    <= adx[31:0];
            ay_q    <= ady[31:0];
            cnt_q   <= '0;
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd4) begin
            cnt_q <= '0;
            sh_q  <= sts.acc[63:0];
            if (sts.acc[AccW-1:64] != '0) begin
              err_q   <= '1;
              state_q <= S_ACC;
            end else begin
              state_q <= S_SQS;
            end
          end
        end
        S_SQS: begin
          sh_q  <= {sh_q[61:0], 2'b00};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            state_q <= S_SQE;
          end
        end
        S_SQE: begin
          err_q   <= sts.quo[31:0];
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            point_error_q <= err_q;
            error_sum_q   <= sum_sat;
            depth_fault_q <= fault_q;
            batch_end_q   <= last_q;
            accum_q       <= last_q ? '0 : sum_sat;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign point_error_o = point_error_q;
  assign error_sum_o   = error_sum_q;
  assign depth_fault_o = depth_fault_q;
  assign batch_end_o   = batch_end_q;

endmodule

// ===== src/rea_alu.sv =====
module rea_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rea_pkg::rea_ctl_t ctl_i,
  output rea_pkg::rea_sts_t sts_o
);
  import rea_pkg::*;

  logic signed [AccW-1:0]   acc_q;
  logic [RemW-1:0]          rem_q;
  logic [QuoW-1:0]          quo_q;
  logic                     ovf_q;
  logic signed [OpAW+OpBW-1:0] prod;
  logic [RemW-1:0]          div_t;
  logic [RemW-1:0]          div_r;
  logic [35:0]              sq_t;
  logic [35:0]              sq_trial;
  logic [35:0]              sq_r;

  assign prod     = ctl_i.a * ctl_i.b;
  assign div_t    = {rem_q[RemW-2:0], ctl_i.bits[0]};
  assign div_r    = div_t - RemW'(ctl_i.den);
  assign sq_t     = {rem_q[33:0], ctl_i.bits};
  assign sq_trial = {2'b00, quo_q[31:0], 2'b01};
  assign sq_r     = sq_t - sq_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      case (ctl_i.op)
        OP_LOAD:  acc_q <= AccW'(prod);
        OP_MAC:   acc_q <= acc_q + AccW'(prod);
        OP_MACSH: acc_q <= acc_q + (AccW'(prod) <<< 16);
        OP_DIV_INIT: begin
          rem_q <= ctl_i.init;
          quo_q <= '0;
          ovf_q <= (ctl_i.init >= RemW'(ctl_i.den));
        end
        OP_DIV_STEP: begin
          if (div_t >= RemW'(ctl_i.den)) begin
            rem_q <= div_r;
            quo_q <= {quo_q[QuoW-2:0], 1'b1};
          end else begin
            rem_q <= div_t;
            quo_q <= {quo_q[QuoW-2:0], 1'b0};
          end
        end
        OP_SQ_INIT: begin
          rem_q <= '0;
          quo_q <= '0;
        end
        OP_SQ_STEP: begin
          if (sq_t >= sq_trial) begin
            rem_q <= RemW'(sq_r);
            quo_q <= {quo_q[QuoW-2:0], 1'b1};
          end else begin
            rem_q <= RemW'(sq_t);
            quo_q <= {quo_q[QuoW-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  assign sts_o.acc = acc_q;
  assign sts_o.quo = quo_q;
  assign sts_o.ovf = ovf_q;

endmodule

// ===== tb/sv/reprojection_error_checker.sv =====
module reprojection_error_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic [31:0] observed_u_i,
  input  logic [31:0] observed_v_i,
  input  logic        last_point_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] point_error_i,
  input  logic [47:0] error_sum_i,
  input  logic        depth_fault_i,
  input  logic        batch_end_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import rea_pkg::*;

  localparam logic [63:0] Max32 = 64'hFFFF_FFFF;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] point_error;
    logic [47:0] error_sum;
    logic        depth_fault;
    logic        batch_end;
  } reproj_result_t;

  logic [47:0] rot_row[3];
  logic [62:0] kin_row[3];
  logic [63:0] center_xy;
  logic [31:0] center_z;
  logic [47:0] error_accum;
  reproj_result_t expected_results[$];

  function automatic logic [63:0] int_sqrt(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return r[63:0];
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Projects the point through the configured camera and updates the running sum.
  function automatic reproj_result_t project_point(
    logic [31:0] px, logic [31:0] py, logic [31:0] pz,
    logic [31:0] ou, logic [31:0] ov, logic last);
    reproj_result_t res;
    longint d[3];
    longint b[3];
    longint q[3];
    longint proj[2];
    longint acc;
    longint ax;
    longint ay;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] quo;
    logic [127:0] sq;
    logic [63:0] err;
    logic [48:0] sum;
    logic sat;
    err = Max32;
    sat = 1'b0;
    d[0] = longint'($signed(px)) - longint'($signed(center_xy[31:0]));
    d[1] = longint'($signed(py)) - longint'($signed(center_xy[63:32]));
    d[2] = longint'($signed(pz)) - longint'($signed(center_z));
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++)
        acc += longint'($signed(rot_row[i][16*k +: 16])) * d[k];
      b[i] = (acc + 8192) >>> 14;
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++)
        acc += longint'($signed(kin_row[i][21*k +: 21])) * b[k];
      q[i] = acc;
    end
    res.depth_fault = (q[2] == 0);
    if (!res.depth_fault) begin
      den = magnitude(q[2]);
      for (int i = 0; i < 2; i++) begin
        num = magnitude(q[i]);
        if (num / den > Max32) sat = 1'b1;
        quo = 64'(({64'd0, num} << 16) / {64'd0, den});
        proj[i] = ((q[i] < 0) == (q[2] < 0)) ? -longint'(quo) : longint'(quo);
      end
      if (!sat) begin
        ax = longint'(magnitude(longint'($signed(ou)) - proj[0]));
        ay = longint'(magnitude(longint'($signed(ov)) - proj[1]));
        if (64'(ax) <= Max32 && 64'(ay) <= Max32) begin
          sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
          if (sq[127:64] == '0) err = int_sqrt(sq);
        end
      end
    end
    sum = {1'b0, error_accum} + 49'(err[31:0]);
    res.point_error = err[31:0];
    res.error_sum   = sum[48] ? Max48 : sum[47:0];
    res.batch_end   = last;
    error_accum = last ? '0 : res.error_sum;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reproj_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        rot_row[i] = '0;
        kin_row[i] = '0;
      end
      center_xy = '0;
      center_z = '0;
      error_accum = '0;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegRot0: rot_row[0] = cfg_data_i[47:0];
          RegRot1: rot_row[1] = cfg_data_i[47:0];
          RegRot2: rot_row[2] = cfg_data_i[47:0];
          RegCxy:  center_xy  = cfg_data_i;
          RegCz:   center_z   = cfg_data_i[31:0];
          RegKin0: kin_row[0] = cfg_data_i[62:0];
          RegKin1: kin_row[1] = cfg_data_i[62:0];
          RegKin2: kin_row[2] = cfg_data_i[62:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", {32'd0, point_error_i}, '0);
        end else begin
          want = expected_results.pop_front();
          if (point_error_i !== want.point_error)
            report_mismatch("point_error", 64'(point_error_i), 64'(want.point_error));
          if (error_sum_i !== want.error_sum)
            report_mismatch("error_sum", 64'(error_sum_i), 64'(want.error_sum));
          if (depth_fault_i !== want.depth_fault)
            report_mismatch("depth_fault", 64'(depth_fault_i), 64'(want.depth_fault));
          if (batch_end_i !== want.batch_end)
            report_mismatch("batch_end", 64'(batch_end_i), 64'(want.batch_end));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.insert(expected_results.size(),
                                project_point(point_x_i, point_y_i, point_z_i,
                                              observed_u_i, observed_v_i, last_point_i));
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== tb/sv/reprojection_error_accumulator_tb.sv =====
module reprojection_error_accumulator_tb;
  import rea_pkg::*;

  localparam int CycleLimit = 3_000_000;
  localparam int DrainCycles = 250;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] u;
    logic [31:0] v;
    logic        last;
  } world_point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic [31:0] point_z = '0;
  logic [31:0] observed_u = '0;
  logic [31:0] observed_v = '0;
  logic        last_point = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] point_error;
  logic [47:0] error_sum;
  logic        depth_fault;
  logic        batch_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] center_z_now = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  reprojection_error_accumulator dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .observed_u_i(observed_u), .observed_v_i(observed_v), .last_point_i(last_point),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .point_error_o(point_error), .error_sum_o(error_sum),
    .depth_fault_o(depth_fault), .batch_end_o(batch_end),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  reprojection_error_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .observed_u_i(observed_u), .observed_v_i(observed_v), .last_point_i(last_point),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .point_error_i(point_error), .error_sum_i(error_sum),
    .depth_fault_i(depth_fault), .batch_end_i(batch_end),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i)
    out_stall <= ($urandom_range(99) < stall_pct);

  task automatic write_reg(logic [3:0] idx, logic [63:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic send_point(world_point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    {point_x, point_y, point_z, observed_u, observed_v, last_point} = p;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [62:0] pack_kin(logic [20:0] k0, logic [20:0] k1, logic [20:0] k2);
    return {k2, k1, k0};
  endfunction

  // Loads one camera setting. Realistic settings use an identity-like rotation and
  // a pinhole intrinsic matrix, so that most points land in a sensible image range.
  task automatic load_camera(int setting);
    logic [15:0] one_r;
    logic [31:0] cx;
    logic [31:0] cy;
    one_r = 16'h4000;
    cx = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    cy = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    center_z_now = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    case (setting)
      0, 6: begin
        if (setting == 6) one_r = 16'hC000;
        write_reg(RegRot0, 64'({16'd0, 16'd0, one_r}));
        write_reg(RegRot1, 64'({16'd0, one_r, 16'd0}));
        write_reg(RegRot2, 64'({16'h4000, 16'd0, 16'd0}));
        write_reg(RegCxy, {cy, cx});
        write_reg(RegCz, {$urandom(), center_z_now});
        write_reg(RegKin0, 64'(pack_kin(21'(800 << 8), 21'd0, 21'(320 << 8))));
        write_reg(RegKin1, 64'(pack_kin(21'd0, 21'(800 << 8), 21'(240 << 8))));
        write_reg(RegKin2, 64'(pack_kin(21'd0, 21'd0, 21'd256)));
      end
      1: begin
        write_reg(RegRot0, 64'({16'($urandom_range(0, 511)), 16'($urandom_range(0, 511)),
                                16'h3F00}));
        write_reg(RegRot1, 64'({16'($urandom_range(0, 511)), 16'h3F00, 16'hFF80}));
        write_reg(RegRot2, 64'({16'h3F00, 16'hFF80, 16'($urandom_range(0, 511))}));
        write_reg(RegCxy, {cy, cx});
        write_reg(RegCz, 64'(center_z_now));
        write_reg(RegKin0, 64'(pack_kin(21'($urandom_range(1, 1 << 19)),
                                        21'($urandom_range(0, 99)),
                                        21'($urandom_range(0, 1 << 18)))));
        write_reg(RegKin1, 64'(pack_kin(21'd0, 21'($urandom_range(1, 1 << 19)),
                                        21'($urandom_range(0, 1 << 18)))));
        write_reg(RegKin2, 64'(pack_kin(21'd0, 21'd0, 21'($urandom_range(1, 1024)))));
      end
      2: begin
        for (int r = RegRot0; r <= RegKin2; r++) write_reg(4'(r), rand64());
        center_z_now = 32'($urandom());
      end
      3: begin
        // All entries at their most negative value.
        for (int r = RegRot0; r <= RegRot2; r++)
          write_reg(4'(r), 64'({16'h8000, 16'h8000, 16'h8000}));
        write_reg(RegCxy, {32'h8000_0000, 32'h8000_0000});
        write_reg(RegCz, 64'h8000_0000);
        center_z_now = 32'h8000_0000;
        for (int r = RegKin0; r <= RegKin2; r++)
          write_reg(4'(r), 64'(pack_kin(21'h100000, 21'h100000, 21'h100000)));
      end
      4: begin
        // All entries at their most positive value.
        for (int r = RegRot0; r <= RegRot2; r++)
          write_reg(4'(r), 64'({16'h7FFF, 16'h7FFF, 16'h7FFF}));
        write_reg(RegCxy, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        write_reg(RegCz, 64'h7FFF_FFFF);
        center_z_now = 32'h7FFF_FFFF;
        for (int r = RegKin0; r <= RegKin2; r++)
          write_reg(4'(r), 64'(pack_kin(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF)));
      end
      5: begin
        // Every bit of every register set; each field reads as minus one.
        for (int r = RegRot0; r <= RegKin2; r++) write_reg(4'(r), '1);
        center_z_now = '1;
      end
      default: begin
        for (int r = RegRot0; r <= RegKin2; r++) write_reg(4'(r), '0);
        center_z_now = '0;
      end
    endcase
    // Writes to indexes outside the register map must leave the camera untouched.
    write_reg(4'($urandom_range(8, 15)), rand64());
  endtask

  function automatic world_point_t random_point();
    world_point_t p;
    p.last = ($urandom_range(7) == 0);
    if ($urandom_range(99) < 70) begin
      p.x = 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      p.y = 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      p.z = center_z_now + 32'($urandom_range(0, 40 << 16));
      p.u = 32'($signed($urandom_range(0, 4000 << 16)) - (2000 << 16));
      p.v = 32'($signed($urandom_range(0, 4000 << 16)) - (2000 << 16));
    end else begin
      p.x = $urandom();
      p.y = $urandom();
      p.z = $urandom();
      p.u = $urandom();
      p.v = $urandom();
    end
    return p;
  endfunction

  task automatic wait_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    world_point_t p;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed points with the reset camera (every depth is zero), then a pinhole camera.
    p = '{x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: 32'd0, u: 32'd0, v: 32'hFFFF_FFFF, last: 1'b0};
    send_point(p);
    p.last = 1'b1;
    send_point(p);
    wait_idle();
    load_camera(0);
    p = '{x: 32'd0, y: 32'd0, z: 32'(10 << 16) + center_z_now, u: 32'd0, v: 32'd0, last: 1'b0};
    send_point(p);
    p.z = center_z_now;
    send_point(p);
    p = '{x: 32'h7FFF_FFFF, y: 32'h7FFF_FFFF, z: 32'h7FFF_FFFF,
          u: 32'h7FFF_FFFF, v: 32'h7FFF_FFFF, last: 1'b0};
    send_point(p);
    p = '{x: 32'h8000_0000, y: 32'h8000_0000, z: 32'h8000_0000,
          u: 32'h8000_0000, v: 32'h8000_0000, last: 1'b1};
    send_point(p);
    p = '{x: 32'h0001_0000, y: 32'hFFFF_0000, z: center_z_now + 32'd1,
          u: 32'h8000_0000, v: 32'h7FFF_FFFF, last: 1'b0};
    send_point(p);
    p = '{x: 32'h0000_0001, y: 32'h0000_0001, z: center_z_now + 32'(1 << 16),
          u: 32'hFFFF_FFFF, v: 32'h0000_0001, last: 1'b1};
    send_point(p);

    for (int phase = 0; phase < 16; phase++) begin
      wait_idle();
      load_camera((phase < 8) ? phase : $urandom_range(0, 2));
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      for (int n = 0; n < 100; n++) send_point(random_point());
      in_valid = 1'b0;
    end

    stall_pct = 0;
    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rea_pkg.sv
src/rea_alu.sv
src/reprojection_error_accumulator.sv
tb/sv/reprojection_error_checker.sv
tb/sv/reprojection_error_accumulator_tb.sv
